FILE: hw/rtl/tch_pkg.sv
package tch_pkg;

    localparam int OS_SLOTS    = 256;
    localparam int TOTAL_SLOTS = 1280;
    localparam int COUNT_WIDTH = 32;
    localparam int SLOT_WIDTH  = $clog2(TOTAL_SLOTS);
    localparam int OUT_WIDTH   = 32;

    localparam logic [15:0] TOOLBOX_SELECT = 16'h0800;
    localparam logic [15:0] TOOLBOX_MASK   = 16'h03FF;
    localparam logic [15:0] OS_MASK        = 16'h00FF;

    localparam logic [SLOT_WIDTH-1:0] LAST_SLOT = SLOT_WIDTH'(TOTAL_SLOTS - 1);

    typedef logic [SLOT_WIDTH-1:0]  t_slot;
    typedef logic [COUNT_WIDTH-1:0] t_count;

    typedef enum logic [1:0] {
        OP_RECORD = 2'd0,
        OP_READ   = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NONE   = 2'd3
    } t_op;

    // Toolbox traps land above the OS block; result is clamped to the table.
    function automatic t_slot slot_of(input logic [15:0] word);
        logic [SLOT_WIDTH:0] slot;
        if ((word & TOOLBOX_SELECT) != 16'h0000) begin
            slot = (SLOT_WIDTH+1)'(OS_SLOTS) + (SLOT_WIDTH+1)'(word & TOOLBOX_MASK);
        end else begin
            slot = (SLOT_WIDTH+1)'(word & OS_MASK);
        end
        if (slot > (SLOT_WIDTH+1)'(TOTAL_SLOTS - 1)) begin
            slot = (SLOT_WIDTH+1)'(TOTAL_SLOTS - 1);
        end
        return slot[SLOT_WIDTH-1:0];
    endfunction

endpackage

FILE: hw/rtl/tch_ram.sv
module tch_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Read returns old data on a same-address collision.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/trap_call_histogram.sv
// Trap call histogram: 1280 32-bit counters held in one synchronous RAM.
// A transaction is taken on a rising edge with start high and busy low. Records and
// reads are pipelined as a two-stage read-modify-write: a new transaction is taken
// every cycle while busy is low, the counter write lands in the cycle after
// acceptance, and back-to-back hits on the same slot are forwarded from the last
// write. A read returns its count on o_count with o_valid high for exactly one cycle,
// registered through stage 1 and the result register; the receiver cannot stall, so
// results must be captured on that cycle. A clear walks the RAM one slot per cycle
// and holds busy high after the clear is taken until the last slot is written. The
// same sweep runs after reset, so busy is high out of reset until it completes.
// Records and clears give no result; operation code 3 is accepted and ignored.
module trap_call_histogram
    import tch_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic [1:0]           i_operation,
    input  logic [15:0]          i_trap_word,
    output logic                 o_valid,
    output logic [OUT_WIDTH-1:0] o_count
);

    // Stage 1: transaction waiting for its RAM read data
    logic   r_p_valid;
    t_op    r_p_op;
    t_slot  r_p_slot;

    // Last counter write, used to forward over the RAM read latency
    logic   r_w_valid;
    t_slot  r_w_slot;
    t_count r_w_data;

    // Clear sweep
    logic   r_clearing;
    t_slot  r_sweep;

    // Result register
    logic                 r_valid;
    logic [OUT_WIDTH-1:0] r_count;

    logic   accept;
    t_op    in_op;
    t_slot  in_slot;
    t_count rd_data;
    t_count cur_count;
    t_count n_count;
    logic   ram_we;
    t_slot  ram_waddr;
    t_count ram_wdata;
    logic   rec_write;

    assign accept  = start && !r_clearing;
    assign in_op   = t_op'(i_operation);
    assign in_slot = slot_of(i_trap_word);

    // Forward the write that collided with this transaction's read.
    assign cur_count = (r_w_valid && r_w_slot == r_p_slot) ? r_w_data : rd_data;
    assign n_count   = cur_count + t_count'(1);
    assign rec_write = r_p_valid && r_p_op == OP_RECORD;

    always_comb begin
        if (r_clearing) begin
            ram_we    = 1'b1;
            ram_waddr = r_sweep;
            ram_wdata = '0;
        end else begin
            ram_we    = rec_write;
            ram_waddr = r_p_slot;
            ram_wdata = n_count;
        end
    end

    tch_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TOTAL_SLOTS)
    ) u_counts (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (in_slot),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid  <= 1'b0;
            r_w_valid  <= 1'b0;
            r_clearing <= 1'b1;
            r_sweep    <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_p_valid <= accept;
            r_valid   <= r_p_valid && r_p_op == OP_READ;
            r_w_valid <= rec_write && !r_clearing;

            if (r_clearing) begin
                r_sweep <= r_sweep + t_slot'(1);
                if (r_sweep == LAST_SLOT) begin
                    r_clearing <= 1'b0;
                end
            end else if (accept && in_op == OP_CLEAR) begin
                // Stage-1 record (if any) writes this cycle, ahead of the sweep.
                r_clearing <= 1'b1;
                r_sweep    <= '0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_p_op   <= in_op;
        r_p_slot <= in_slot;
        r_w_slot <= r_p_slot;
        r_w_data <= n_count;
        r_count  <= OUT_WIDTH'(cur_count);
    end

    assign busy    = r_clearing;
    assign o_valid = r_valid;
    assign o_count = r_count;

`ifndef NO_ASSERTIONS
    // A result only follows a read in stage 1.
    a_result_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_p_valid && r_p_op == OP_READ))
        else $error("result without a read transaction");

    // Nothing is accepted while the sweep owns the RAM write port.
    a_no_accept_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clearing |=> !r_p_valid)
        else $error("transaction accepted during clear sweep");

    // The sweep stays inside the table and advances each cycle out of reset.
    a_sweep_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rst_n && r_clearing && r_sweep != LAST_SLOT && $past(r_clearing))
        |=> r_sweep == $past(r_sweep) + t_slot'(1))
        else $error("clear sweep skipped a slot");

    // Forwarding source is never left over from before a clear.
    a_no_stale_forward: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clearing) |-> !r_w_valid)
        else $error("forward register valid across clear");
`endif

endmodule
